/* sv/block_cache_tag_manager_core_macros.svh */
// assertion macros shared by the block cache tag manager rtl
`ifndef BLOCK_CACHE_TAG_MANAGER_CORE_MACROS_SVH
`define BLOCK_CACHE_TAG_MANAGER_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define BCTM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bctm check failed");

// consequent must hold in the cycle after the antecedent
`define BCTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bctm check failed");

`endif

/* sv/bctm_pkg.sv */
// shared types, widths and codes of the block cache tag manager
`timescale 1ns / 1ps
`default_nettype none

package bctm_pkg;

	// default sizing of the tag store
	localparam int ENTRIES_DEF  = 512;
	localparam int TAG_BITS_DEF = 48;

	// field widths of the request, response and configuration transactions
	localparam int BLOCK_W     = 48;
	localparam int SLOT_W      = 9;
	localparam int FIRST_LBA_W = 60;
	localparam int XFER_W      = 13;
	localparam int LPB_W       = 13;
	localparam int TOTAL_W     = 48;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 48;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LBAS_PER_BLOCK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LBA_TOTAL      = 2'd1;

	// configuration reset values
	localparam logic [LPB_W-1:0]   LPB_RESET   = 13'd8;
	localparam logic [TOTAL_W-1:0] TOTAL_RESET = 48'd0;

	// multi-cycle start address product: 13 bits times 16-bit slices
	localparam int MUL_CHUNK = 16;
	localparam int MUL_STEPS = BLOCK_W / MUL_CHUNK;
	localparam int MUL_CNT_W = 2;
	localparam int PP_W      = LPB_W + MUL_CHUNK;
	localparam int START_W   = LPB_W + BLOCK_W;
	localparam int DIFF_W    = START_W + 1;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL,
		ST_DIFF,
		ST_DONE
	} bctm_state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
		logic mul;
		logic diff;
		logic load;
	} bctm_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic scan_done;
		logic mul_done;
		logic out_free;
	} bctm_sts_t;

endpackage

`default_nettype wire

/* sv/bctm_if.sv */
// request, response and configuration channel interfaces
`timescale 1ns / 1ps
`default_nettype none

// lookup request channel
interface bctm_req_if import bctm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               operation;
	logic [BLOCK_W-1:0] block_number;

	modport source (output valid, operation, block_number, input ready);
	modport sink (input valid, operation, block_number, output ready);
endinterface

// lookup response channel
interface bctm_rsp_if import bctm_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   hit;
	logic [SLOT_W-1:0]      slot;
	logic                   fetch_needed;
	logic                   write_through;
	logic [FIRST_LBA_W-1:0] first_lba;
	logic [XFER_W-1:0]      transfer_lbas;
	logic                   out_of_range;

	modport source (output valid, hit, slot, fetch_needed, write_through, first_lba,
		transfer_lbas, out_of_range, input ready);
	modport sink (input valid, hit, slot, fetch_needed, write_through, first_lba,
		transfer_lbas, out_of_range, output ready);
endinterface

// configuration register write channel
interface bctm_cfg_if import bctm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/bctm_ctrl.sv */
// controller state machine sequencing scan, product, clamp and result load
`timescale 1ns / 1ps
`default_nettype none

module bctm_ctrl import bctm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  bctm_sts_t sts,
	output bctm_cmd_t cmd
);

	bctm_state_t state_q;
	bctm_state_t state_next;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) state_next = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_done) state_next = ST_MUL;
			end
			ST_MUL: begin
				if (sts.mul_done) state_next = ST_DIFF;
			end
			ST_DIFF: begin
				state_next = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// command outputs
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.start = req_valid;
			end
			ST_SCAN: begin
				cmd.scan   = 1'b1;
				cmd.commit = sts.scan_done;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
			end
			ST_DONE: begin
				cmd.load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* sv/bctm_datapath.sv */
// tag store, fill and victim tracking, start product, clamp and result register
`timescale 1ns / 1ps
`default_nettype none
`include "block_cache_tag_manager_core_macros.svh"

module bctm_datapath import bctm_pkg::*; #(
	parameter int ENTRIES  = ENTRIES_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bctm_cmd_t              cmd,
	output bctm_sts_t              sts,
	input  logic                   operation,
	input  logic [BLOCK_W-1:0]     block_number,
	input  logic                   cfg_valid,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output logic                   hit,
	output logic [SLOT_W-1:0]      slot,
	output logic                   fetch_needed,
	output logic                   write_through,
	output logic [FIRST_LBA_W-1:0] first_lba,
	output logic [XFER_W-1:0]      transfer_lbas,
	output logic                   out_of_range
);

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	// configuration registers
	logic [LPB_W-1:0]   lpb_q;
	logic [TOTAL_W-1:0] total_q;

	// request held for the whole transaction
	logic               op_q;
	logic [BLOCK_W-1:0] block_q;
	logic [TAG_BITS-1:0] tag_q;

	// tag store and replacement state
	logic [TAG_BITS-1:0] tag_mem [ENTRIES];
	logic [CW-1:0]       fill_q;
	logic [CW-1:0]       vp_q;

	// scan pipeline
	logic [CW-1:0]       rd_idx_q;
	logic                rd_en;
	logic                cmp_valid_s1;
	logic [AW-1:0]       cmp_idx_s1;
	logic [TAG_BITS-1:0] rdata_s1;
	logic                match;
	logic                full;
	logic [CW-1:0]       vp_wrap;
	logic [AW-1:0]       miss_target;
	logic                mem_we;

	// lookup outcome
	logic          hit_q;
	logic [AW-1:0] target_q;

	// start address product
	logic [MUL_CNT_W-1:0] mul_cnt_q;
	logic [MUL_CHUNK-1:0] mul_chunk;
	logic [PP_W-1:0]      pp_s1;
	logic [MUL_CNT_W-1:0] pp_sel_s1;
	logic                 pp_valid_s1;
	logic [START_W-1:0]   pp_shifted;
	logic [START_W-1:0]   acc_q;

	// clamp against device end
	logic [DIFF_W-1:0] diff_q;
	logic              oor;
	logic              fits;
	logic [XFER_W-1:0] count;

	// result register
	logic                   out_valid_q;
	logic                   out_hit_q;
	logic [SLOT_W-1:0]      out_slot_q;
	logic                   out_wt_q;
	logic [FIRST_LBA_W-1:0] out_lba_q;
	logic [XFER_W-1:0]      out_xfer_q;
	logic                   out_oor_q;

	// configuration writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpb_q   <= LPB_RESET;
			total_q <= TOTAL_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LBAS_PER_BLOCK: lpb_q   <= cfg_data[LPB_W-1:0];
				CFG_LBA_TOTAL:      total_q <= cfg_data[TOTAL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q    <= operation;
			block_q <= block_number;
			tag_q   <= TAG_BITS'(block_number);
		end
	end

	// valid entries always form a prefix, so the fill count stands for the valid bits
	assign rd_en       = cmd.scan && (rd_idx_q < fill_q);
	assign match       = cmp_valid_s1 && (rdata_s1 == tag_q);
	assign full        = (fill_q == CW'(ENTRIES));
	assign vp_wrap     = (vp_q >= CW'(ENTRIES)) ? '0 : vp_q;
	assign miss_target = full ? vp_wrap[AW-1:0] : fill_q[AW-1:0];
	assign mem_we      = cmd.commit && !match;

	assign sts.scan_done = match || (!cmp_valid_s1 && (rd_idx_q >= fill_q));

	// tag store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tag_mem[miss_target] <= tag_q;
		end
		if (rd_en) begin
			rdata_s1   <= tag_mem[rd_idx_q[AW-1:0]];
			cmp_idx_s1 <= rd_idx_q[AW-1:0];
		end
	end

	// scan control, fill count and victim pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q     <= '0;
			cmp_valid_s1 <= 1'b0;
			fill_q       <= '0;
			vp_q         <= '0;
		end else begin
			if (cmd.start) begin
				rd_idx_q     <= '0;
				cmp_valid_s1 <= 1'b0;
			end else if (cmd.scan) begin
				cmp_valid_s1 <= rd_en;
				if (rd_en) rd_idx_q <= rd_idx_q + CW'(1);
			end
			if (mem_we) begin
				if (full) begin
					vp_q <= vp_wrap + CW'(1);
				end else begin
					fill_q <= fill_q + CW'(1);
				end
			end
		end
	end

	// lookup outcome capture
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q    <= match;
			target_q <= match ? cmp_idx_s1 : miss_target;
		end
	end

	// slice of the block number for the current partial product
	always_comb begin
		case (mul_cnt_q)
			2'd0:    mul_chunk = block_q[0 * MUL_CHUNK +: MUL_CHUNK];
			2'd1:    mul_chunk = block_q[1 * MUL_CHUNK +: MUL_CHUNK];
			2'd2:    mul_chunk = block_q[2 * MUL_CHUNK +: MUL_CHUNK];
			default: mul_chunk = '0;
		endcase
	end

	// partial product aligned to its slice
	always_comb begin
		case (pp_sel_s1)
			2'd0:    pp_shifted = START_W'(pp_s1);
			2'd1:    pp_shifted = START_W'(pp_s1) << MUL_CHUNK;
			2'd2:    pp_shifted = START_W'(pp_s1) << (2 * MUL_CHUNK);
			default: pp_shifted = '0;
		endcase
	end

	// product sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_cnt_q   <= '0;
			pp_valid_s1 <= 1'b0;
		end else if (cmd.start) begin
			mul_cnt_q   <= '0;
			pp_valid_s1 <= 1'b0;
		end else if (cmd.mul) begin
			pp_valid_s1 <= (mul_cnt_q < MUL_CNT_W'(MUL_STEPS));
			if (mul_cnt_q < MUL_CNT_W'(MUL_STEPS)) mul_cnt_q <= mul_cnt_q + MUL_CNT_W'(1);
		end
	end

	assign sts.mul_done = (mul_cnt_q == MUL_CNT_W'(MUL_STEPS)) && !pp_valid_s1;

	// partial product and accumulation
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
		end else if (cmd.mul) begin
			if (mul_cnt_q < MUL_CNT_W'(MUL_STEPS)) begin
				pp_s1     <= PP_W'(lpb_q) * PP_W'(mul_chunk);
				pp_sel_s1 <= mul_cnt_q;
			end
			if (pp_valid_s1) acc_q <= acc_q + pp_shifted;
		end
	end

	// distance from start to device end, negative when start lies beyond it
	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			diff_q <= DIFF_W'(total_q) - DIFF_W'(acc_q);
		end
	end

	assign oor   = diff_q[DIFF_W-1];
	assign fits  = (diff_q <= DIFF_W'(lpb_q));
	assign count = oor ? '0 : (fits ? diff_q[XFER_W-1:0] : lpb_q);

	assign sts.out_free = !out_valid_q || rsp_ready;

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_hit_q  <= hit_q;
			out_slot_q <= SLOT_W'(target_q);
			out_wt_q   <= op_q;
			out_lba_q  <= acc_q[FIRST_LBA_W-1:0];
			out_xfer_q <= count;
			out_oor_q  <= oor;
		end
	end

	assign rsp_valid     = out_valid_q;
	assign hit           = out_hit_q;
	assign slot          = out_slot_q;
	assign fetch_needed  = !out_hit_q;
	assign write_through = out_wt_q;
	assign first_lba     = out_lba_q;
	assign transfer_lbas = out_xfer_q;
	assign out_of_range  = out_oor_q;

	// checks on fill count, victim pointer and chosen slot
	`BCTM_ASSERT_NOW(a_fill_bound, clk, arst_n, 1'b1, fill_q <= CW'(ENTRIES))
	`BCTM_ASSERT_NOW(a_vp_bound, clk, arst_n, 1'b1, vp_q <= CW'(ENTRIES))
	`BCTM_ASSERT_NEXT(a_fill_step, clk, arst_n, mem_we && !full, fill_q == $past(fill_q) + CW'(1))
	`BCTM_ASSERT_NEXT(a_slot_valid, clk, arst_n, cmd.commit, CW'(target_q) < fill_q)

endmodule

`default_nettype wire

/* sv/block_cache_tag_manager_core.sv */
// top level of the block cache tag manager: controller, datapath and channel wiring
// one request at a time; a scan reads one tag entry per cycle from the tag memory
// request to result valid runs through scan, product, clamp and load; the scan stops at the hit
// entry, or runs over the whole fill count on a miss; the next request is taken the cycle after the
// result register is loaded, and the load waits while a previous result is still unread
// reset empties the cache through the fill count at once; lbas_per_block 8, lba_total 0
`timescale 1ns / 1ps
`default_nettype none

module block_cache_tag_manager_core import bctm_pkg::*; #(
	parameter int ENTRIES  = ENTRIES_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	bctm_req_if.sink   req,
	bctm_rsp_if.source rsp,
	bctm_cfg_if.sink   cfg
);

	bctm_cmd_t cmd;
	bctm_sts_t sts;

	// configuration writes always taken
	assign cfg.ready = 1'b1;

	// sequencing
	bctm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// lookup and address datapath
	bctm_datapath #(
		.ENTRIES  (ENTRIES),
		.TAG_BITS (TAG_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (req.operation),
		.block_number  (req.block_number),
		.cfg_valid     (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.rsp_valid     (rsp.valid),
		.rsp_ready     (rsp.ready),
		.hit           (rsp.hit),
		.slot          (rsp.slot),
		.fetch_needed  (rsp.fetch_needed),
		.write_through (rsp.write_through),
		.first_lba     (rsp.first_lba),
		.transfer_lbas (rsp.transfer_lbas),
		.out_of_range  (rsp.out_of_range)
	);

endmodule

`default_nettype wire
